>>> design/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

    localparam logic [7:0] START_BYTE   = 8'h99;
    localparam logic [7:0] LEN_OVERHEAD = 8'd4;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_RECV    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_SUM_A   = 3'd3,
        PH_SUM_B   = 3'd4
    } phase_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } wr_t;

    typedef struct packed {
        logic       message_ready;
        logic [7:0] frame_length;
        logic [7:0] overrun_count;
        logic [7:0] error_count;
        logic       frame_done;
        logic       frame_error;
    } stat_t;

endpackage

`default_nettype wire

>>> design/fpr_payload_ram.sv
`default_nettype none

module fpr_payload_ram (
    input  wire logic          aclk,
    input  wire fpr_pkg::wr_t  wr,
    input  wire logic          rd_en,
    input  wire logic [7:0]    rd_addr,
    output logic [7:0]         rd_data_reg
);

    logic [7:0] mem [256];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/fpr_frame_ctrl.sv
`default_nettype none

module fpr_frame_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire fpr_pkg::op_t    op,
    input  wire logic [7:0]      rx_byte,
    output fpr_pkg::wr_t         wr,
    output fpr_pkg::stat_t       stat_next
);

    fpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic       pending_reg, pending_next;
    logic [7:0] overruns_reg, overruns_next;
    logic [7:0] errors_reg, errors_next;
    logic       done;
    logic       err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= fpr_pkg::PH_HUNT;
            len_reg      <= '0;
            pos_reg      <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            pending_reg  <= 1'b0;
            overruns_reg <= '0;
            errors_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            pending_reg  <= pending_next;
            overruns_reg <= overruns_next;
            errors_reg   <= errors_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        pending_next  = pending_reg;
        overruns_next = overruns_reg;
        errors_next   = errors_reg;
        done          = 1'b0;
        err           = 1'b0;
        wr.en         = 1'b0;
        wr.addr       = pos_reg;
        wr.data       = rx_byte;

        if (accept) begin
            case (op)
                fpr_pkg::OP_RECV: begin
                    case (phase_reg)
                        fpr_pkg::PH_HUNT: begin
                            if (rx_byte == fpr_pkg::START_BYTE) begin
                                phase_next = fpr_pkg::PH_LENGTH;
                            end
                        end
                        fpr_pkg::PH_LENGTH: begin
                            if (pending_reg) begin
                                overruns_next = overruns_reg + 8'd1;
                                err           = 1'b1;
                            end else begin
                                len_next   = rx_byte - fpr_pkg::LEN_OVERHEAD;
                                sum_a_next = rx_byte;
                                sum_b_next = rx_byte;
                                pos_next   = '0;
                                phase_next = fpr_pkg::PH_PAYLOAD;
                            end
                        end
                        fpr_pkg::PH_PAYLOAD: begin
                            wr.en      = 1'b1;
                            sum_a_next = sum_a_reg + rx_byte;
                            sum_b_next = sum_b_reg + sum_a_next;
                            pos_next   = pos_reg + 8'd1;
                            // zero length wraps through all 256 positions
                            if (pos_next == len_reg) begin
                                phase_next = fpr_pkg::PH_SUM_A;
                            end
                        end
                        fpr_pkg::PH_SUM_A: begin
                            if (rx_byte != sum_a_reg) begin
                                err = 1'b1;
                            end else begin
                                phase_next = fpr_pkg::PH_SUM_B;
                            end
                        end
                        fpr_pkg::PH_SUM_B: begin
                            if (rx_byte != sum_b_reg) begin
                                err = 1'b1;
                            end else begin
                                pending_next = 1'b1;
                                done         = 1'b1;
                                phase_next   = fpr_pkg::PH_HUNT;
                            end
                        end
                        default: begin
                            err = 1'b1;
                        end
                    endcase
                    if (err) begin
                        errors_next = errors_reg + 8'd1;
                        phase_next  = fpr_pkg::PH_HUNT;
                    end
                end
                fpr_pkg::OP_RELEASE: begin
                    pending_next = 1'b0;
                end
                default: begin
                end
            endcase
        end

        stat_next.message_ready = pending_next;
        stat_next.frame_length  = len_next;
        stat_next.overrun_count = overruns_next;
        stat_next.error_count   = errors_next;
        stat_next.frame_done    = done;
        stat_next.frame_error   = err;
    end

endmodule

`default_nettype wire

>>> design/framed_packet_receiver.sv
// Stage one registers the payload RAM read of an accepted input word, and
// the output register then holds the result word. Throughput: one word
// per cycle unless m_tready stalls the output; the RAM has one write and
// one read port, so a payload write and a host read never compete.
// Reset: aresetn (synchronous, active low) clears the frame state, sums,
// counters and pipeline valids; the payload RAM is not cleared.
`default_nettype none

module framed_packet_receiver (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // rx_byte [7:0], read_index [15:8]
    input  wire logic [fpr_pkg::S_TDATA_W-1:0]   s_tdata,
    // op [1:0]
    input  wire logic [fpr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_data [7:0], message_ready [8], frame_length [16:9],
    // overrun_count [24:17], error_count [32:25], frame_done [33],
    // frame_error [34], zero [39:35]
    output logic [fpr_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic           accept;
    logic           advance;
    fpr_pkg::op_t   op;
    fpr_pkg::wr_t   wr;
    fpr_pkg::stat_t stat_next;
    logic [7:0]     rd_data;

    logic           p1_valid_reg;
    logic           p1_read_reg;
    fpr_pkg::stat_t p1_stat_reg;
    logic           out_valid_reg;
    logic [fpr_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [7:0]     read_data;

    assign op       = fpr_pkg::op_t'(s_tuser);
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    fpr_frame_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (op),
        .rx_byte   (s_tdata[7:0]),
        .wr        (wr),
        .stat_next (stat_next)
    );

    // read only on accept so the data holds while stage one stalls
    fpr_payload_ram u_ram (
        .aclk        (aclk),
        .wr          (wr),
        .rd_en       (accept),
        .rd_addr     (s_tdata[15:8]),
        .rd_data_reg (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_stat_reg <= stat_next;
            p1_read_reg <= (op == fpr_pkg::OP_READ);
        end
    end

    assign read_data = p1_read_reg ? rd_data : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            out_data_reg <= {5'd0,
                             p1_stat_reg.frame_error,
                             p1_stat_reg.frame_done,
                             p1_stat_reg.error_count,
                             p1_stat_reg.overrun_count,
                             p1_stat_reg.frame_length,
                             p1_stat_reg.message_ready,
                             read_data};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> design/fpr_checker.sv
`default_nettype none

module fpr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [fpr_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [fpr_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_done_xor_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("frame done and frame error together");

    a_done_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[8])
        else $error("completed frame without message ready");

    a_recv_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33] || m_tdata[34]) |-> m_tdata[7:0] == 8'd0)
        else $error("read data on a receive word");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
